// ===== hw/rtl/hse_pkg.sv =====
package hse_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int VALUE_W          = 32;

  // write data source for the element store
  typedef enum logic [1:0] {
    WSEL_IN,
    WSEL_ITEM,
    WSEL_RD0,
    WSEL_RD1
  } wsel_t;

  typedef struct packed {
    logic  we;
    wsel_t wsel;
    logic  item_ld;
    logic  out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic right_gt;       // rd1 > rd0
    logic left_gt_item;   // rd0 > item
    logic right_gt_item;  // rd1 > item
  } dp_stat_t;

endpackage

// ===== hw/rtl/hse_datapath.sv =====
module hse_datapath #(
  parameter int MAX_ELEMENTS = hse_pkg::MAX_ELEMENTS_DEF,
  parameter int ADDR_W       = $clog2(MAX_ELEMENTS)
) (
  input  logic                               clk,
  input  hse_pkg::dp_cmd_t                   cmd,
  input  logic [ADDR_W-1:0]                  waddr,
  input  logic [ADDR_W-1:0]                  raddr0,
  input  logic [ADDR_W-1:0]                  raddr1,
  input  logic signed [hse_pkg::VALUE_W-1:0] in_value,
  output hse_pkg::dp_stat_t                  stat,
  output logic signed [hse_pkg::VALUE_W-1:0] out_sorted_value
);

  localparam int DEPTH = 1 << ADDR_W;

  logic signed [hse_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [hse_pkg::VALUE_W-1:0] rd0_r;
  logic signed [hse_pkg::VALUE_W-1:0] rd1_r;
  logic signed [hse_pkg::VALUE_W-1:0] item_r;
  logic signed [hse_pkg::VALUE_W-1:0] out_value_r;
  logic signed [hse_pkg::VALUE_W-1:0] wdata;

  always_comb begin
    unique case (cmd.wsel)
      hse_pkg::WSEL_IN:   wdata = in_value;
      hse_pkg::WSEL_ITEM: wdata = item_r;
      hse_pkg::WSEL_RD0:  wdata = rd0_r;
      hse_pkg::WSEL_RD1:  wdata = rd1_r;
      default:            wdata = item_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      item_r <= rd0_r;
    end
    if (cmd.out_ld) begin
      out_value_r <= rd0_r;
    end
  end

  assign stat.right_gt      = rd1_r > rd0_r;
  assign stat.left_gt_item  = rd0_r > item_r;
  assign stat.right_gt_item = rd1_r > item_r;

  assign out_sorted_value = out_value_r;

endmodule

// ===== hw/rtl/hse_ctrl.sv =====
module hse_ctrl #(
  parameter int MAX_ELEMENTS = hse_pkg::MAX_ELEMENTS_DEF,
  parameter int ADDR_W       = $clog2(MAX_ELEMENTS),
  parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_last_element,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last_result,
  output logic              out_truncated,
  input  hse_pkg::dp_stat_t stat,
  output hse_pkg::dp_cmd_t  cmd,
  output logic [ADDR_W-1:0] waddr,
  output logic [ADDR_W-1:0] raddr0,
  output logic [ADDR_W-1:0] raddr1
);

  localparam int CMP_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ELEMENTS);

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_BLD_RD,
    S_BLD_ITEM,
    S_SIFT_CHK,
    S_SIFT_CMP,
    S_EXT_RD,
    S_EXT_SWAP,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  len_r;
  logic [ADDR_W-1:0] hole_r;
  logic              build_r;
  logic              out_valid_r;
  logic              out_last_r;
  logic              out_trunc_r;

  logic [ADDR_W:0]   kid;
  logic [CMP_W-1:0]  kid_ext;
  logic [CMP_W-1:0]  kid1_ext;
  logic [CMP_W-1:0]  len_ext;
  logic              kid_in;
  logic              use_right;
  logic              win_gt;
  logic              in_fire;
  logic              store_ok;
  logic              more_build;
  logic [CNT_W-1:0]  len_dec;
  logic [CNT_W-1:0]  idx_dec;

  assign kid      = {hole_r, 1'b1};
  assign kid_ext  = CMP_W'(kid);
  assign kid1_ext = kid_ext + CMP_W'(1);
  assign len_ext  = CMP_W'(len_r);
  assign kid_in   = kid_ext < len_ext;
  // right child only counts while it lies inside the heap
  assign use_right  = (kid1_ext < len_ext) && stat.right_gt;
  assign win_gt     = use_right ? stat.right_gt_item : stat.left_gt_item;
  assign in_fire    = in_valid && in_ready;
  assign store_ok   = count_r < CAP;
  assign more_build = build_r && (idx_r > CNT_W'(1));
  assign len_dec    = len_r - CNT_W'(1);
  assign idx_dec    = idx_r - CNT_W'(1);

  assign in_ready        = (state_r == S_LOAD);
  assign out_valid       = out_valid_r;
  assign out_last_result = out_last_r;
  assign out_truncated   = out_trunc_r;

  always_comb begin
    cmd.we      = 1'b0;
    cmd.wsel    = hse_pkg::WSEL_ITEM;
    cmd.item_ld = 1'b0;
    cmd.out_ld  = 1'b0;
    waddr       = hole_r;
    raddr0      = idx_r[ADDR_W-1:0];
    raddr1      = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.we   = in_fire && store_ok;
        cmd.wsel = hse_pkg::WSEL_IN;
        waddr    = count_r[ADDR_W-1:0];
      end
      S_BLD_RD: begin
        raddr0 = idx_dec[ADDR_W-1:0];
      end
      S_BLD_ITEM: begin
        cmd.item_ld = 1'b1;
      end
      S_SIFT_CHK: begin
        raddr0 = kid[ADDR_W-1:0];
        raddr1 = kid1_ext[ADDR_W-1:0];
        if (!kid_in) begin
          cmd.we   = 1'b1;
          cmd.wsel = hse_pkg::WSEL_ITEM;
        end
      end
      S_SIFT_CMP: begin
        cmd.we = 1'b1;
        if (win_gt) begin
          cmd.wsel = use_right ? hse_pkg::WSEL_RD1 : hse_pkg::WSEL_RD0;
        end else begin
          cmd.wsel = hse_pkg::WSEL_ITEM;
        end
      end
      S_EXT_RD: begin
        raddr0 = len_dec[ADDR_W-1:0];
        raddr1 = '0;
      end
      S_EXT_SWAP: begin
        // old root goes to the slot just dropped from the heap
        cmd.item_ld = 1'b1;
        cmd.we      = 1'b1;
        cmd.wsel    = hse_pkg::WSEL_RD1;
        waddr       = len_r[ADDR_W-1:0];
      end
      S_EMIT_RD: begin
        raddr0 = idx_r[ADDR_W-1:0];
      end
      S_EMIT_LD: begin
        cmd.out_ld = 1'b1;
      end
      S_START, S_EMIT_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      len_r       <= '0;
      hole_r      <= '0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_trunc_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (store_ok) begin
              count_r <= count_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_element) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          len_r   <= count_r;
          build_r <= 1'b1;
          if ((count_r >> 1) != '0) begin
            idx_r   <= count_r >> 1;
            state_r <= S_BLD_RD;
          end else begin
            idx_r   <= '0;
            state_r <= S_EMIT_RD;
          end
        end
        S_BLD_RD: begin
          hole_r  <= ADDR_W'(idx_r - CNT_W'(1));
          state_r <= S_BLD_ITEM;
        end
        S_BLD_ITEM: begin
          state_r <= S_SIFT_CHK;
        end
        S_SIFT_CHK, S_SIFT_CMP: begin
          if (state_r == S_SIFT_CHK && kid_in) begin
            state_r <= S_SIFT_CMP;
          end else if (state_r == S_SIFT_CMP && win_gt) begin
            hole_r  <= use_right ? kid1_ext[ADDR_W-1:0] : kid[ADDR_W-1:0];
            state_r <= S_SIFT_CHK;
          end else if (more_build) begin
            idx_r   <= idx_r - CNT_W'(1);
            state_r <= S_BLD_RD;
          end else begin
            build_r <= 1'b0;
            if (len_r > CNT_W'(1)) begin
              state_r <= S_EXT_RD;
            end else begin
              idx_r   <= '0;
              state_r <= S_EMIT_RD;
            end
          end
        end
        S_EXT_RD: begin
          len_r   <= len_dec;
          state_r <= S_EXT_SWAP;
        end
        S_EXT_SWAP: begin
          hole_r  <= '0;
          state_r <= S_SIFT_CHK;
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (idx_r + CNT_W'(1)) == count_r;
          out_trunc_r <= ovf_r;
          state_r     <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              idx_r   <= idx_r + CNT_W'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/heap_sort_engine.sv =====
// Heapsort engine. Signed 32-bit values stream in one per transaction, one
// per cycle while loading, into an internal store of MAX_ELEMENTS entries;
// the transaction with in_last_element set closes the set and starts an
// in-place heapsort (max-heap build, then root extraction). Values beyond
// capacity are dropped and every result of that set carries out_truncated.
// Results then leave in ascending order, out_last_result on the greatest.
// A set of n elements is loaded, then sifted down: n/2 sifts for the build
// plus n-1 for extraction, each over at most log2(n) heap levels; each
// result is then read, loaded and held until the sink takes it. Each level
// of the sift loop fetches both children through the store's registered
// two-port read in S_SIFT_CHK, then compares and writes back in S_SIFT_CMP.
// No new set is accepted until the last result of the current one is taken.
module heap_sort_engine #(
  parameter int MAX_ELEMENTS = hse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hse_pkg::VALUE_W-1:0] in_value,
  input  logic                               in_last_element,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hse_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                               out_last_result,
  output logic                               out_truncated
);

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

  hse_pkg::dp_cmd_t  cmd;
  hse_pkg::dp_stat_t stat;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;

  hse_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ADDR_W       (ADDR_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_last_result (out_last_result),
    .out_truncated   (out_truncated),
    .stat            (stat),
    .cmd             (cmd),
    .waddr           (waddr),
    .raddr0          (raddr0),
    .raddr1          (raddr1)
  );

  hse_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ADDR_W       (ADDR_W)
  ) u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .waddr            (waddr),
    .raddr0           (raddr0),
    .raddr1           (raddr1),
    .in_value         (in_value),
    .stat             (stat),
    .out_sorted_value (out_sorted_value)
  );

endmodule
